// File: rtl/truth_table_pn_canonicalizer_unit_macros.svh
// assertion helpers shared by the rtl
`ifndef TRUTH_TABLE_PN_CANONICALIZER_UNIT_MACROS_SVH
`define TRUTH_TABLE_PN_CANONICALIZER_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpc assertion failed");

// next-cycle implication, disabled while in reset
`define TPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpc assertion failed");

`endif

// File: rtl/tpc_pkg.sv
package tpc_pkg;

  localparam int MAX_VARS  = 4;
  localparam int VAR_LIMIT = (MAX_VARS < 4) ? MAX_VARS : 4;

  localparam int NVAR_W = 3;
  localparam int CODE_W = 16;
  localparam int PMAP_W = 8;
  localparam int NEG_W  = 4;

  typedef logic [1:0]      pos_t;
  typedef pos_t [3:0]      order_t;

  // candidate order from last element f and lex rank r of the other positions
  function automatic order_t unrank_order(logic [2:0] n, pos_t f, logic [2:0] r);
    pos_t       rem [3];
    pos_t       rem2 [2];
    pos_t       pick [4];
    logic [1:0] k;
    logic [1:0] d0;
    logic       d1;
    logic [2:0] m;
    order_t     ord;
    rem[0] = '0;
    rem[1] = '0;
    rem[2] = '0;
    k = '0;
    // remaining variables in ascending order
    for (int e = 0; e < 4; e++) begin
      if (3'(e) < n && 2'(e) != f && k != 2'd3) begin
        rem[k] = 2'(e);
        k = k + 2'd1;
      end
    end
    m = n - 3'd1;
    // factorial digits of the rank
    d0 = (m == 3'd3) ? r[2:1] : ((m == 3'd2) ? {1'b0, r[0]} : 2'd0);
    d1 = (m == 3'd3) ? r[0] : 1'b0;
    case (d0)
      2'd0:    pick[0] = rem[0];
      2'd1:    pick[0] = rem[1];
      default: pick[0] = rem[2];
    endcase
    rem2[0] = (d0 == 2'd0) ? rem[1] : rem[0];
    rem2[1] = (d0 == 2'd2) ? rem[1] : rem[2];
    pick[1] = d1 ? rem2[1] : rem2[0];
    pick[2] = d1 ? rem2[0] : rem2[1];
    pick[3] = '0;
    for (int j = 0; j < 4; j++) begin
      if (3'(j) < m)
        ord[j] = pick[j];
      else if (3'(j) == m)
        ord[j] = f;
      else
        ord[j] = 2'(j);
    end
    return ord;
  endfunction

  // remap table entries under an input permutation and negation mask
  function automatic logic [CODE_W-1:0] transform_code(logic [CODE_W-1:0] code,
                                                       logic [2:0] n, order_t ord,
                                                       logic [NEG_W-1:0] neg);
    logic [4:0]        size;
    logic [3:0]        ii;
    logic [3:0]        place;
    logic [2:0]        src;
    logic [2:0]        dst;
    logic [CODE_W-1:0] res;
    size = 5'd1 << n;
    res  = '0;
    for (int i = 0; i < CODE_W; i++) begin
      if (5'(i) < size) begin
        ii    = 4'(i);
        place = '0;
        for (int j = 0; j < 4; j++) begin
          if (3'(j) < n) begin
            src = n - 3'd1 - 3'(j);
            dst = n - 3'd1 - {1'b0, ord[j]};
            place[dst[1:0]] = ii[src[1:0]] ^ neg[j];
          end
        end
        res[4'(size - 5'd1 - 5'(i))] = code[4'(size - 5'd1 - {1'b0, place})];
      end
    end
    return res;
  endfunction

endpackage

// File: rtl/truth_table_pn_canonicalizer_unit.sv
// channel | ports                                             | direction
// in      | in_valid, in_ready, in_num_vars, in_table_code    | request in
// out     | out_valid, out_ready, out_canonical_code,         | result out
//         | out_perm_map, out_neg_mask                        |
// one candidate transform per cycle through the shared remap/compare unit:
// all n! * 2^n candidates for n inputs are tried (384 at four inputs, none at
// zero), then the result waits in S_DONE until the output register is free
// in_ready is low from acceptance until the result is loaded
// the output register lets the next request enter while a result waits
// rst_n clears the sequencer and output valid; no clearing pass
`include "truth_table_pn_canonicalizer_unit_macros.svh"

module truth_table_pn_canonicalizer_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tpc_pkg::NVAR_W-1:0]  in_num_vars,
  input  logic [tpc_pkg::CODE_W-1:0]  in_table_code,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tpc_pkg::CODE_W-1:0]  out_canonical_code,
  output logic [tpc_pkg::PMAP_W-1:0]  out_perm_map,
  output logic [tpc_pkg::NEG_W-1:0]   out_neg_mask
);
  import tpc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  state_t            state_r, state_nxt;
  logic [2:0]        n_r, n_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [CODE_W-1:0] best_r, best_nxt;
  order_t            best_ord_r, best_ord_nxt;
  logic [NEG_W-1:0]  best_neg_r, best_neg_nxt;
  pos_t              f_r, f_nxt;
  logic [2:0]        r_r, r_nxt;
  logic [3:0]        c_r, c_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] out_code_r, out_code_nxt;
  logic [PMAP_W-1:0] out_pmap_r, out_pmap_nxt;
  logic [NEG_W-1:0]  out_neg_r, out_neg_nxt;

  logic [2:0]        n_sat;
  logic [16:0]       in_mask;
  order_t            cand_ord;
  logic [NEG_W-1:0]  cand_neg;
  logic [CODE_W-1:0] cand_code;
  logic [3:0]        last_c;
  logic [2:0]        last_r;
  logic [PMAP_W-1:0] pmap;
  logic              load_out;

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_canonical_code = out_code_r;
  assign out_perm_map       = out_pmap_r;
  assign out_neg_mask       = out_neg_r;

  // saturate input count and mask the unused table bits
  assign n_sat   = (in_num_vars > 3'(VAR_LIMIT)) ? 3'(VAR_LIMIT) : in_num_vars;
  assign in_mask = (17'd1 << (5'd1 << n_sat)) - 17'd1;

  // candidate generation: order from (f, r), negation from bit-reversed c
  always_comb begin
    cand_ord = unrank_order(n_r, f_r, r_r);
    cand_neg = '0;
    for (int j = 0; j < NEG_W; j++) begin
      if (3'(j) < n_r)
        cand_neg[j] = c_r[2'(n_r - 3'd1 - 3'(j))];
    end
    cand_code = transform_code(code_r, n_r, cand_ord, cand_neg);
  end

  // loop bounds
  assign last_c = 4'((5'd1 << n_r) - 5'd1);
  always_comb begin
    unique case (n_r)
      3'd4:    last_r = 3'd5;
      3'd3:    last_r = 3'd1;
      default: last_r = 3'd0;
    endcase
  end

  // pack the winning order, unused fields zero
  always_comb begin
    pmap = '0;
    for (int j = 0; j < 4; j++) begin
      if (3'(j) < n_r)
        pmap[2*j +: 2] = best_ord_r[j];
    end
  end

  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    code_nxt      = code_r;
    best_nxt      = best_r;
    best_ord_nxt  = best_ord_r;
    best_neg_nxt  = best_neg_r;
    f_nxt         = f_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_code_nxt  = out_code_r;
    out_pmap_nxt  = out_pmap_r;
    out_neg_nxt   = out_neg_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt        = n_sat;
          code_nxt     = in_table_code & in_mask[CODE_W-1:0];
          best_nxt     = in_table_code & in_mask[CODE_W-1:0];
          best_ord_nxt = {2'd3, 2'd2, 2'd1, 2'd0};
          best_neg_nxt = '0;
          f_nxt        = '0;
          r_nxt        = '0;
          c_nxt        = '0;
          state_nxt    = (n_sat == 3'd0) ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        // strict improvement keeps the earliest minimum
        if (cand_code < best_r) begin
          best_nxt     = cand_code;
          best_ord_nxt = cand_ord;
          best_neg_nxt = cand_neg;
        end
        if (c_r == last_c) begin
          c_nxt = '0;
          if (r_r == last_r) begin
            r_nxt = '0;
            if (f_r == 2'(n_r - 3'd1))
              state_nxt = S_DONE;
            else
              f_nxt = f_r + 2'd1;
          end else begin
            r_nxt = r_r + 3'd1;
          end
        end else begin
          c_nxt = c_r + 4'd1;
        end
      end
      S_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = best_r;
          out_pmap_nxt  = pmap;
          out_neg_nxt   = best_neg_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      code_r      <= code_nxt;
      best_r      <= best_nxt;
      best_ord_r  <= best_ord_nxt;
      best_neg_r  <= best_neg_nxt;
      f_r         <= f_nxt;
      r_r         <= r_nxt;
      c_r         <= c_nxt;
      out_code_r  <= out_code_nxt;
      out_pmap_r  <= out_pmap_nxt;
      out_neg_r   <= out_neg_nxt;
    end
  end

  // running minimum never grows during the search
  `TPC_ASSERT_NEXT(a_best_monotone, clk, rst_n, state_r == S_RUN, best_r <= $past(best_r))
  // reported code never exceeds the masked input
  `TPC_ASSERT_NEXT(a_out_le_input, clk, rst_n, load_out, out_code_r <= $past(code_r))
  // negation bits above the input count stay clear
  `TPC_ASSERT_NEXT(a_neg_unused, clk, rst_n, load_out, (out_neg_r >> $past(n_r)) == 4'd0)
  // fixed last element stays inside the active inputs
  `TPC_ASSERT_SAME(a_f_range, clk, rst_n, state_r == S_RUN, {1'b0, f_r} < n_r)

endmodule

// File: test/truth_table_pn_canonicalizer_unit_checker.sv
`timescale 1ns / 1ps

module truth_table_pn_canonicalizer_unit_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [tpc_pkg::NVAR_W-1:0]  in_num_vars,
  input  logic [tpc_pkg::CODE_W-1:0]  in_table_code,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [tpc_pkg::CODE_W-1:0]  out_canonical_code,
  input  logic [tpc_pkg::PMAP_W-1:0]  out_perm_map,
  input  logic [tpc_pkg::NEG_W-1:0]   out_neg_mask,
  output int                          error_count,
  output int                          pending_count
);

  typedef struct packed {
    logic [tpc_pkg::CODE_W-1:0] code;
    logic [tpc_pkg::PMAP_W-1:0] pmap;
    logic [tpc_pkg::NEG_W-1:0]  neg;
  } pn_form_t;

  pn_form_t canon_q [$];

  // table seen through an input order and negation mask
  function automatic logic [tpc_pkg::CODE_W-1:0] remap_table(
      logic [tpc_pkg::CODE_W-1:0] code, int n, logic [7:0] ord_map, logic [3:0] neg);
    int size;
    int place;
    int b;
    logic [tpc_pkg::CODE_W-1:0] res;
    size = 1 << n;
    res  = '0;
    for (int i = 0; i < size; i++) begin
      place = 0;
      for (int j = 0; j < n; j++) begin
        b = ((i >> (n - 1 - j)) & 1) ^ neg[j];
        place = place | (b << (n - 1 - int'(ord_map[2*j +: 2])));
      end
      if (code[size - 1 - place])
        res[size - 1 - i] = 1'b1;
    end
    return res;
  endfunction

  // exhaustive search: last element outer, lex order inside, then negation counter
  function automatic pn_form_t canonical_search(logic [2:0] nv,
                                                logic [tpc_pkg::CODE_W-1:0] table_in);
    int n;
    int size;
    int pw;
    int rem;
    int d [4];
    bit distinct;
    logic [31:0] mask32;
    logic [tpc_pkg::CODE_W-1:0] masked;
    logic [7:0] ord_map;
    logic [3:0] neg;
    logic [tpc_pkg::CODE_W-1:0] cand;
    pn_form_t best;
    n      = (int'(nv) > tpc_pkg::VAR_LIMIT) ? tpc_pkg::VAR_LIMIT : int'(nv);
    size   = 1 << n;
    mask32 = (32'd1 << size) - 32'd1;
    masked = table_in & mask32[tpc_pkg::CODE_W-1:0];
    best.code = masked;
    best.pmap = '0;
    best.neg  = '0;
    // identity order fills the used fields
    for (int j = 0; j < n; j++)
      best.pmap[2*j +: 2] = 2'(j);
    pw = 1;
    for (int j = 0; j < n; j++)
      pw = pw * n;
    for (int f = 0; f < n; f++) begin
      for (int idx = 0; idx < pw; idx++) begin
        rem = idx;
        for (int j = n - 1; j >= 0; j--) begin
          d[j] = rem % n;
          rem  = rem / n;
        end
        distinct = (d[n-1] == f);
        for (int a = 0; a < n; a++)
          for (int c = a + 1; c < n; c++)
            if (d[a] == d[c])
              distinct = 1'b0;
        if (distinct) begin
          ord_map = '0;
          for (int j = 0; j < n; j++)
            ord_map[2*j +: 2] = 2'(d[j]);
          for (int c = 0; c < size; c++) begin
            neg = '0;
            for (int j = 0; j < n; j++)
              neg[j] = 1'((c >> (n - 1 - j)) & 1);
            cand = remap_table(masked, n, ord_map, neg);
            if (cand < best.code) begin
              best.code = cand;
              best.pmap = ord_map;
              best.neg  = neg;
            end
          end
        end
      end
    end
    return best;
  endfunction

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t ns: %s mismatch: got %h expected %h", $time, field, got, want);
    error_count = error_count + 1;
  endtask

  initial begin
    error_count   = 0;
    pending_count = 0;
  end

  // record each accepted request, then check each accepted result
  always @(posedge clk) begin
    pn_form_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        canon_q = {canon_q, canonical_search(in_num_vars, in_table_code)};
      if (out_valid && out_ready) begin
        if (canon_q.size() == 0) begin
          report_mismatch("unexpected result", out_canonical_code, '0);
        end else begin
          want = canon_q.pop_front();
          if (out_canonical_code !== want.code)
            report_mismatch("canonical_code", out_canonical_code, want.code);
          if (out_perm_map !== want.pmap)
            report_mismatch("perm_map", 16'(out_perm_map), 16'(want.pmap));
          if (out_neg_mask !== want.neg)
            report_mismatch("neg_mask", 16'(out_neg_mask), 16'(want.neg));
        end
      end
      pending_count = canon_q.size();
    end
  end

endmodule

// File: test/truth_table_pn_canonicalizer_unit_tb.sv
`timescale 1ns / 1ps

module truth_table_pn_canonicalizer_unit_tb;

  localparam int PHASE_ITEMS  = 500;
  localparam int PRESSURE_AT  = 1100;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 400;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [tpc_pkg::NVAR_W-1:0]  in_num_vars = '0;
  logic [tpc_pkg::CODE_W-1:0]  in_table_code = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [tpc_pkg::CODE_W-1:0]  out_canonical_code;
  logic [tpc_pkg::PMAP_W-1:0]  out_perm_map;
  logic [tpc_pkg::NEG_W-1:0]   out_neg_mask;

  int error_count;
  int pending_count;
  int sent_count = 0;
  int send_idle_pct = 16;
  int recv_idle_pct = 70;

  truth_table_pn_canonicalizer_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_num_vars        (in_num_vars),
    .in_table_code      (in_table_code),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_canonical_code (out_canonical_code),
    .out_perm_map       (out_perm_map),
    .out_neg_mask       (out_neg_mask)
  );

  truth_table_pn_canonicalizer_unit_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_num_vars        (in_num_vars),
    .in_table_code      (in_table_code),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_canonical_code (out_canonical_code),
    .out_perm_map       (out_perm_map),
    .out_neg_mask       (out_neg_mask),
    .error_count        (error_count),
    .pending_count      (pending_count)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #50_000_000;
    $display("truth_table_pn_canonicalizer_unit_tb: errors");
    $finish;
  end

  // offer one request, with random idle cycles ahead of it
  task automatic offer_request(input logic [2:0] nv, input logic [15:0] code);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_num_vars   <= nv;
    in_table_code <= code;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // result side: random stalls plus one long hold-off
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && sent_count >= PRESSURE_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // stimulus and verdict
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no variables, high bits ignored
    offer_request(3'd0, 16'h0000);
    offer_request(3'd0, 16'hFFFE);
    offer_request(3'd0, 16'h0001);
    // one variable, every table, then two- and three-variable tables
    offer_request(3'd1, 16'h0000);
    offer_request(3'd1, 16'h0001);
    offer_request(3'd1, 16'h0002);
    offer_request(3'd1, 16'h0003);
    offer_request(3'd1, 16'hFFFC);
    offer_request(3'd2, 16'h0006);
    offer_request(3'd2, 16'h0009);
    offer_request(3'd3, 16'h0096);
    offer_request(3'd3, 16'hFF17);
    // four variables: constants, single minterms, parity and other tables
    offer_request(3'd4, 16'h0000);
    offer_request(3'd4, 16'hFFFF);
    offer_request(3'd4, 16'h8000);
    offer_request(3'd4, 16'h0001);
    offer_request(3'd4, 16'h6996);
    offer_request(3'd4, 16'hAAAA);
    offer_request(3'd4, 16'h00FF);
    offer_request(3'd4, 16'h1234);
    // too many variables saturate
    offer_request(3'd5, 16'($urandom));
    offer_request(3'd6, 16'($urandom));
    offer_request(3'd7, 16'($urandom));

    for (int k = 0; k < 3 * PHASE_ITEMS; k++) begin
      if (k == PHASE_ITEMS) begin
        send_idle_pct = 70;
        recv_idle_pct = 16;
      end else if (k == 2 * PHASE_ITEMS) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      offer_request(3'($urandom_range(0, 7)), 16'($urandom));
    end
    in_valid <= 1'b0;

    // drain
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_count == 0)
      $display("truth_table_pn_canonicalizer_unit_tb: clean");
    else
      $display("truth_table_pn_canonicalizer_unit_tb: errors");
    $finish;
  end

endmodule
